/* rtl/sliding_window_mean_defines.svh */
// assertion macros for the sliding window mean block
// included by the top level only; no other dependencies
`ifndef SLIDING_WINDOW_MEAN_DEFINES_SVH
`define SLIDING_WINDOW_MEAN_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define SWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sliding_window_mean: same-cycle check failed");
// next-cycle implication
`define SWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding_window_mean: next-cycle check failed");
`else
`define SWM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SWM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/swm_pkg.sv */
// shared constants and control structs for the sliding window mean block
// no dependencies
package swm_pkg;

  // defaults for the top-level parameters
  localparam int DEFAULT_WINDOW_DEPTH = 256;
  localparam int DEFAULT_SAMPLE_BITS  = 32;

  // fixed field widths
  localparam int IN_W   = 32;
  localparam int MEAN_W = 32;
  localparam int LEN_W  = 9;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic update;
    logic div_start;
    logic out_load;
  } swm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
  } swm_sts_t;

endpackage

/* rtl/swm_if.sv */
// valid/ready channel interfaces for samples in and means out
// depends on swm_pkg
interface swm_in_if import swm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IN_W-1:0]   sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface swm_out_if import swm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MEAN_W-1:0] window_mean;
  logic [LEN_W-1:0]  fill_count;

  modport source (output valid, output window_mean, output fill_count, input ready);
  modport sink   (input valid, input window_mean, input fill_count, output ready);
endinterface

/* rtl/swm_div.sv */
// restoring divider, one quotient bit per cycle
// no package dependencies
module swm_div #(
  parameter int NUM_W = 41,
  parameter int DEN_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             busy,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] q_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [DEN_W:0]   rem_sub;

  // one restoring step
  always_comb begin
    rem_sh  = {rem_r, q_r[NUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_sub = rem_sh - {1'b0, den_r};
  end

  // control: bit counter and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

/* rtl/swm_datapath.sv */
// datapath: window length register, ring store, running sum, divider, output word
// depends on swm_pkg and swm_div
module swm_datapath import swm_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic [IN_W-1:0]   sample_value,
  input  swm_cmd_t          cmd,
  output swm_sts_t          sts,
  output logic [MEAN_W-1:0] window_mean,
  output logic [LEN_W-1:0]  fill_count
);

  localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int WIDE_W = (SAMPLE_BITS > IN_W) ? SAMPLE_BITS : IN_W;
  localparam logic [WIDE_W-1:0] SAMPLE_MAX = WIDE_W'((65'(1) << SAMPLE_BITS) - 65'(1));

  logic [LEN_W-1:0]       len_r;
  logic [ADDR_W-1:0]      pos_r;
  logic [CNT_W-1:0]       held_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SAMPLE_BITS-1:0] old_r;
  logic [MEAN_W-1:0]      mean_r;
  logic [LEN_W-1:0]       count_r;
  logic [SAMPLE_BITS-1:0] store [WINDOW_DEPTH];

  logic [CMP_W-1:0]       len_ext;
  logic [CNT_W-1:0]       eff_len;
  logic [ADDR_W-1:0]      pos_eff;
  logic [CNT_W-1:0]       pos_inc;
  logic [WIDE_W-1:0]      in_ext;
  logic [SAMPLE_BITS-1:0] sample_sat;
  logic [SUM_W-1:0]       quotient;

  // effective window length: zero acts as one, clamp to the store depth
  always_comb begin
    len_ext = CMP_W'(len_r);
    if (len_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (len_ext > CMP_W'(WINDOW_DEPTH)) begin
      eff_len = CNT_W'(WINDOW_DEPTH);
    end else begin
      eff_len = CNT_W'(len_ext);
    end
  end

  // slot for this word and the one after it
  always_comb begin
    pos_eff = (CNT_W'(pos_r) >= eff_len) ? '0 : pos_r;
    pos_inc = CNT_W'(pos_eff) + CNT_W'(1);
  end

  // saturate the incoming sample to the store width
  always_comb begin
    in_ext     = WIDE_W'(sample_value);
    sample_sat = SAMPLE_BITS'((in_ext > SAMPLE_MAX) ? SAMPLE_MAX : in_ext);
  end

  // window length register and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= LEN_RESET;
      pos_r  <= '0;
      held_r <= '0;
      sum_r  <= '0;
    end else if (cfg_wr_en) begin
      len_r  <= cfg_wr_data;
      pos_r  <= '0;
      held_r <= '0;
      sum_r  <= '0;
    end else if (cmd.update) begin
      pos_r <= (pos_inc >= eff_len) ? '0 : ADDR_W'(pos_inc);
      if (held_r < eff_len) begin
        held_r <= held_r + CNT_W'(1);
        sum_r  <= sum_r + SUM_W'(sample_r);
      end else begin
        held_r <= eff_len;
        sum_r  <= sum_r + SUM_W'(sample_r) - SUM_W'(old_r);
      end
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= sample_sat;
    end
  end

  // ring store: registered read, then write back into the same slot
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      old_r <= store[pos_eff];
    end
    if (cmd.update) begin
      store[pos_eff] <= sample_r;
    end
  end

  swm_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (held_r),
    .busy     (sts.div_busy),
    .quotient (quotient)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_r  <= MEAN_W'(quotient);
      count_r <= LEN_W'(held_r);
    end
  end

  assign window_mean = mean_r;
  assign fill_count  = count_r;

endmodule

/* rtl/swm_ctrl.sv */
// controller: sequences read, update, divide and output load for each word
// depends on swm_pkg
module swm_ctrl import swm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  swm_sts_t sts,
  output swm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_START,
    S_DIVIDE,
    S_HOLD
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;
  logic   load;

  assign out_free = !out_valid_r || out_ready;

  // output word may be loaded once the divider is done and the slot is free
  always_comb begin
    load = 1'b0;
    if ((state_r == S_DIVIDE && !sts.div_busy) || state_r == S_HOLD) begin
      load = out_free;
    end
  end

  // commands decoded from state
  always_comb begin
    in_ready      = (state_r == S_IDLE);
    cmd.capture   = in_ready && in_valid;
    cmd.mem_rd    = (state_r == S_READ);
    cmd.update    = (state_r == S_UPDATE);
    cmd.div_start = (state_r == S_START);
    cmd.out_load  = load;
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_READ;
          end
        end
        S_READ:   state_r <= S_UPDATE;
        S_UPDATE: state_r <= S_START;
        S_START:  state_r <= S_DIVIDE;
        S_DIVIDE: begin
          if (!sts.div_busy) begin
            state_r <= load ? S_IDLE : S_HOLD;
          end
        end
        S_HOLD: begin
          if (load) begin
            state_r <= S_IDLE;
          end
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/sliding_window_mean.sv */
// top level of the sliding window mean block
// depends on swm_pkg, swm_if, swm_ctrl, swm_datapath and the assertion macros
//
// Usage:
//   in_if carries one latency sample per word (sample_value, 32 bits unsigned;
//   values above the store width saturate). out_if returns one word per
//   sample: window_mean, the running sum over the held samples divided by
//   the fill count and truncated, and fill_count, the samples now held.
//   cfg_wr_en/cfg_wr_data write the window length (0 acts as 1, values above
//   WINDOW_DEPTH act as WINDOW_DEPTH); a write clears the window. Write it
//   only while no sample is in flight.
//   The restoring divider works out the mean, one quotient bit per cycle.
//   One word is in work at a time; in_ready rises together with out valid,
//   so a new sample is taken only once the previous word is loaded into
//   the output register.
//   Reset: window length 64, window empty, no output pending.
//   If out_ready stays low, the output register keeps its word; the next
//   sample is still taken and worked, and waits finished until the register
//   frees up.
`include "sliding_window_mean_defines.svh"

module sliding_window_mean import swm_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
  parameter int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  swm_in_if.sink           in_if,
  swm_out_if.source        out_if
);

  swm_cmd_t          cmd;
  swm_sts_t          sts;
  logic              in_ready;
  logic              out_valid;
  logic [MEAN_W-1:0] window_mean;
  logic [LEN_W-1:0]  fill_count;

  swm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swm_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .sample_value (in_if.sample_value),
    .cmd          (cmd),
    .sts          (sts),
    .window_mean  (window_mean),
    .fill_count   (fill_count)
  );

  // channel hookup
  assign in_if.ready        = in_ready;
  assign out_if.valid       = out_valid;
  assign out_if.window_mean = window_mean;
  assign out_if.fill_count  = fill_count;

  // one word in work at a time
  `SWM_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_if.valid && in_ready, !in_ready)
  // the divider runs once started
  `SWM_ASSERT_NXT(a_div_runs, clk, rst_n, cmd.div_start, sts.div_busy)
  // no new word while dividing
  `SWM_ASSERT_IMP(a_busy_blocks_in, clk, rst_n, sts.div_busy, !in_ready)
  // output load never happens mid-divide
  `SWM_ASSERT_IMP(a_load_after_div, clk, rst_n, cmd.out_load, !sts.div_busy)

endmodule
